FILE: rtl/keypad_click_classifier_macros.svh
// Assertion macros shared by the keypad click classifier RTL.
`ifndef KEYPAD_CLICK_CLASSIFIER_MACROS_SVH
`define KEYPAD_CLICK_CLASSIFIER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define KCC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define KCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/kcc_pkg.sv
// Types, constants and helper functions of the keypad click classifier.
`timescale 1ns / 1ps
`default_nettype none

package kcc_pkg;

  localparam int unsigned KCC_KEYS        = 12;
  localparam int unsigned KCC_KEY_W       = 4;
  localparam int unsigned KCC_TIME_W      = 32;
  localparam int unsigned KCC_CFG_W       = 32;
  localparam int unsigned KCC_CFG_INDEX_W = 1;

  localparam logic [KCC_CFG_INDEX_W-1:0] KCC_CFG_LONG_PRESS    = 1'b0;
  localparam logic [KCC_CFG_INDEX_W-1:0] KCC_CFG_DOUBLE_WINDOW = 1'b1;

  localparam logic [KCC_TIME_W-1:0] KCC_LONG_PRESS_RESET    = 32'd1000000;
  localparam logic [KCC_TIME_W-1:0] KCC_DOUBLE_WINDOW_RESET = 32'd300000;

  localparam logic [KCC_KEY_W-1:0] KCC_NO_KEY  = 4'd0;
  localparam logic [KCC_KEY_W-1:0] KCC_MAX_KEY = 4'd12;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } kcc_event_t;

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_PRESSED  = 2'd1,
    MODE_RELEASED = 2'd2,
    MODE_LONG     = 2'd3
  } kcc_mode_t;

  typedef struct packed {
    logic [KCC_KEYS-1:0]   key_levels;
    logic [KCC_TIME_W-1:0] now_us;
  } kcc_in_t;

  typedef struct packed {
    kcc_event_t           event_kind;
    logic [KCC_KEY_W-1:0] event_key;
  } kcc_out_t;

  // Highest numbered key whose level is low, or no key.
  function automatic logic [KCC_KEY_W-1:0] kcc_pick_key(input logic [KCC_KEYS-1:0] levels);
    logic [KCC_KEY_W-1:0] key;
    key = KCC_NO_KEY;
    for (int k = 0; k < KCC_KEYS; k++) begin
      if (!levels[k]) begin
        key = KCC_KEY_W'(k + 1);
      end
    end
    return key;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/keypad_click_classifier.sv
// Top level of the keypad click classifier: channels, settings and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "keypad_click_classifier_macros.svh"

// The keypad click classifier takes one transaction per keypad tick: the
// twelve active-low key levels of a 4x3 matrix and a wrapping microsecond
// timestamp. The highest numbered pressed key is the key of the tick. A
// gesture machine (idle, pressed, released, long press) answers every input
// transaction with exactly one output transaction that carries a single
// click, a double click, a long press or no event, together with the key
// that started the gesture. A transaction is held in the input register and
// then passes the gesture logic into the result register, from which its
// result is offered; a new transaction can be accepted in every cycle while
// a register is free or the result is taken, and the input side keeps taking
// transactions while a finished result waits for out_ready, until both the
// input register and the result register are full. All timeouts use 32-bit
// modular differences, so timestamps may wrap freely. The settings are
// written through cfg_we, cfg_index and cfg_data: index 0 is the hold time
// beyond which a press is long, index 1 is the window after a release in
// which a second press is a double click, which also locks out new presses
// after a double click. Write them only while no transaction is in flight.
// Because the last release time resets to zero, presses are ignored after
// reset until the timestamp has reached the double click window.
module keypad_click_classifier
  import kcc_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire kcc_in_t                    in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output kcc_out_t                        out_data,
  input  wire logic                       cfg_we,
  input  wire logic [KCC_CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [KCC_CFG_W-1:0]       cfg_data
);

  logic [KCC_TIME_W-1:0] long_press_us;
  logic [KCC_TIME_W-1:0] double_window_us;

  logic     stage_valid;
  kcc_in_t  stage_data;
  logic     advance;
  kcc_out_t result;

  // The staged transaction moves on whenever the result register is free
  // or is being emptied in this same cycle.
  assign advance  = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_us    <= KCC_LONG_PRESS_RESET;
      double_window_us <= KCC_DOUBLE_WINDOW_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        KCC_CFG_LONG_PRESS:    long_press_us    <= cfg_data[KCC_TIME_W-1:0];
        KCC_CFG_DOUBLE_WINDOW: double_window_us <= cfg_data[KCC_TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_data <= in_data;
    end
  end

  kcc_gesture u_gesture (
    .clk              (clk),
    .rst              (rst),
    .step             (advance),
    .item             (stage_data),
    .long_press_us    (long_press_us),
    .double_window_us (double_window_us),
    .result           (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  `KCC_ASSERT_NOW(a_none_has_no_key, clk, rst,
    out_valid && (out_data.event_kind == EV_NONE), out_data.event_key == KCC_NO_KEY,
    "event without a kind carries a key")

  `KCC_ASSERT_NOW(a_key_in_range, clk, rst,
    out_valid && (out_data.event_kind != EV_NONE),
    (out_data.event_key != KCC_NO_KEY) && (out_data.event_key <= KCC_MAX_KEY),
    "event key out of range")

  `KCC_ASSERT_NOW(a_stall_only_when_full, clk, rst,
    !in_ready, stage_valid && out_valid && !out_ready,
    "input stalled although a register is free")

  `KCC_ASSERT_NEXT(a_advance_fills_result, clk, rst,
    advance, out_valid,
    "staged transaction lost on its way to the result register")

endmodule

`default_nettype wire

FILE: rtl/kcc_gesture.sv
// Gesture state machine: turns one keypad sample per step into a click event.
`timescale 1ns / 1ps
`default_nettype none

module kcc_gesture
  import kcc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  step,
  input  wire kcc_in_t               item,
  input  wire logic [KCC_TIME_W-1:0] long_press_us,
  input  wire logic [KCC_TIME_W-1:0] double_window_us,
  output kcc_out_t                   result
);

  kcc_mode_t             mode, mode_next;
  logic [KCC_KEY_W-1:0]  held_key, held_key_next;
  logic [KCC_TIME_W-1:0] press_time, press_time_next;
  logic [KCC_TIME_W-1:0] release_time, release_time_next;

  logic [KCC_KEY_W-1:0]  key;
  logic                  key_down;
  logic [KCC_TIME_W-1:0] since_release;
  logic [KCC_TIME_W-1:0] since_press;
  logic                  in_window;
  logic                  long_due;

  // Differences wrap modulo 2^32, so a wrapped timestamp still compares right.
  assign key           = kcc_pick_key(item.key_levels);
  assign key_down      = (key != KCC_NO_KEY);
  assign since_release = item.now_us - release_time;
  assign since_press   = item.now_us - press_time;
  assign in_window     = (since_release < double_window_us);
  assign long_due      = (since_press > long_press_us);

  always_comb begin
    mode_next         = mode;
    held_key_next     = held_key;
    press_time_next   = press_time;
    release_time_next = release_time;
    case (mode)
      MODE_IDLE: begin
        if (!in_window && key_down) begin
          held_key_next   = key;
          press_time_next = item.now_us;
          mode_next       = MODE_PRESSED;
        end
      end
      MODE_PRESSED: begin
        if (!key_down) begin
          release_time_next = item.now_us;
          mode_next         = MODE_RELEASED;
        end else if (long_due) begin
          mode_next = MODE_LONG;
        end
      end
      MODE_RELEASED: begin
        if (in_window) begin
          if (key_down) begin
            release_time_next = item.now_us;
            held_key_next     = KCC_NO_KEY;
            mode_next         = MODE_IDLE;
          end
        end else begin
          held_key_next = KCC_NO_KEY;
          mode_next     = MODE_IDLE;
        end
      end
      MODE_LONG: begin
        if (!key_down) begin
          held_key_next = KCC_NO_KEY;
          mode_next     = MODE_IDLE;
        end
      end
      default: begin
        mode_next = MODE_IDLE;
      end
    endcase
  end

  always_comb begin
    result.event_kind = EV_NONE;
    result.event_key  = KCC_NO_KEY;
    case (mode)
      MODE_PRESSED: begin
        if (key_down && long_due) begin
          result.event_kind = EV_LONG;
          result.event_key  = held_key;
        end
      end
      MODE_RELEASED: begin
        if (!in_window) begin
          result.event_kind = EV_SINGLE;
          result.event_key  = held_key;
        end else if (key_down) begin
          result.event_kind = EV_DOUBLE;
          result.event_key  = held_key;
        end
      end
      default: begin
        result.event_kind = EV_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      held_key     <= KCC_NO_KEY;
      press_time   <= '0;
      release_time <= '0;
    end else if (step) begin
      mode         <= mode_next;
      held_key     <= held_key_next;
      press_time   <= press_time_next;
      release_time <= release_time_next;
    end
  end

endmodule

`default_nettype wire
